>>> rtl/pbsd_pkg.sv
package pbsd_pkg;

  localparam int CODE_W = 8;
  localparam int CFG_W = 13;
  localparam int LEN_W = 8;

  // decode phase codes
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_REPEAT = 2'd2;

  localparam logic [CODE_W-1:0] HDR_NOP = 8'h80;

  typedef struct packed {
    logic [CODE_W-1:0] code_byte;
    logic line_end;
  } in_item_t;

endpackage

>>> rtl/pbsd_in_reg.sv
module pbsd_in_reg (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input pbsd_pkg::in_item_t in_item,
  input logic take,
  output logic full,
  output pbsd_pkg::in_item_t item
);
  import pbsd_pkg::*;

  logic load;

  assign in_stall = full && !take;
  assign load = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

>>> rtl/pbsd_core.sv
module pbsd_core #(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input logic clk,
  input logic rst,
  input logic step,
  input pbsd_pkg::in_item_t item,
  input logic [pbsd_pkg::CFG_W-1:0] line_width,
  output logic has_result,
  output logic [pbsd_pkg::CODE_W-1:0] pixel_value,
  output logic [pbsd_pkg::LEN_W-1:0] run_length,
  output logic [$clog2(MAX_LINE_WIDTH)-1:0] start_column,
  output logic fills_line
);
  import pbsd_pkg::*;

  localparam int CW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int SW = $clog2(MAX_LINE_WIDTH);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;
  localparam int RW = (CW > LEN_W) ? CW : LEN_W;

  logic [1:0] phase, phase_next;
  logic [LEN_W-1:0] literal_left, literal_left_next;
  logic [LEN_W-1:0] repeat_count, repeat_count_next;
  logic [CW-1:0] column, column_next;

  logic [EW-1:0] lw_ext, w_wide;
  logic [CW-1:0] w, room, col_sum;
  logic [RW-1:0] room_ext, rep_ext;
  logic [LEN_W-1:0] len;
  logic [CODE_W-1:0] b;
  logic emit;

  assign b = item.code_byte;
  assign lw_ext = EW'(line_width);

  // clamp width to 1..MAX_LINE_WIDTH
  always_comb begin
    if (lw_ext == '0) begin
      w_wide = EW'(1);
    end else if (lw_ext > EW'(MAX_LINE_WIDTH)) begin
      w_wide = EW'(MAX_LINE_WIDTH);
    end else begin
      w_wide = lw_ext;
    end
  end
  assign w = w_wide[CW-1:0];

  assign room = w - column;
  assign room_ext = RW'(room);
  assign rep_ext = RW'(repeat_count);

  always_comb begin
    phase_next = phase;
    literal_left_next = literal_left;
    repeat_count_next = repeat_count;
    emit = 1'b0;
    len = LEN_W'(1);
    if (column < w) begin
      unique case (phase)
        PH_LITERAL: begin
          emit = 1'b1;
          len = LEN_W'(1);
          if (literal_left != '0) begin
            literal_left_next = literal_left - LEN_W'(1);
          end
          if (literal_left <= LEN_W'(1)) begin
            phase_next = PH_HEADER;
          end
        end
        PH_REPEAT: begin
          emit = 1'b1;
          // clip the run at the line end
          len = (rep_ext > room_ext) ? room_ext[LEN_W-1:0] : repeat_count;
          repeat_count_next = '0;
          phase_next = PH_HEADER;
        end
        default: begin
          priority if (!b[CODE_W-1]) begin
            literal_left_next = b + LEN_W'(1);
            phase_next = PH_LITERAL;
          end else if (b != HDR_NOP) begin
            repeat_count_next = LEN_W'(9'd257 - {1'b0, b});
            phase_next = PH_REPEAT;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      endcase
    end
  end

  assign col_sum = column + CW'(len);
  assign column_next = emit ? col_sum : column;

  assign has_result = emit;
  assign pixel_value = b;
  assign run_length = len;
  assign start_column = column[SW-1:0];
  assign fills_line = (col_sum == w);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      literal_left <= '0;
      repeat_count <= '0;
      column <= '0;
    end else if (step) begin
      if (item.line_end) begin
        phase <= PH_HEADER;
        literal_left <= '0;
        repeat_count <= '0;
        column <= '0;
      end else begin
        phase <= phase_next;
        literal_left <= literal_left_next;
        repeat_count <= repeat_count_next;
        column <= column_next;
      end
    end
  end

endmodule

>>> rtl/packbits_scanline_decoder.sv
// PackBits scanline decoder: takes one compressed byte per cycle while not
// stalled and returns at most one run (value, length, start column,
// line-full flag) per byte. Each accepted byte is held in the input register
// until it is decoded into the output register, when the next byte may load;
// a stalled output holds the input register, and the input stalls only once
// both registers are occupied and the output is stalled.
// line_width is clamped to 1..MAX_LINE_WIDTH and applies from the next byte.
module packbits_scanline_decoder #(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [pbsd_pkg::CFG_W-1:0] cfg_data,
  input logic in_valid,
  output logic in_stall,
  input logic [pbsd_pkg::CODE_W-1:0] code_byte,
  input logic line_end,
  output logic out_valid,
  input logic out_stall,
  output logic [pbsd_pkg::CODE_W-1:0] pixel_value,
  output logic [pbsd_pkg::LEN_W-1:0] run_length,
  output logic [$clog2(MAX_LINE_WIDTH)-1:0] start_column,
  output logic fills_line
);
  import pbsd_pkg::*;

  localparam int SW = $clog2(MAX_LINE_WIDTH);

  logic [CFG_W-1:0] line_width;
  in_item_t in_item, item;
  logic full, step;
  logic has_result;
  logic [CODE_W-1:0] res_value;
  logic [LEN_W-1:0] res_len;
  logic [SW-1:0] res_start;
  logic res_fills;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= CFG_W'(1);
    end else if (cfg_we) begin
      line_width <= cfg_data;
    end
  end

  assign in_item.code_byte = code_byte;
  assign in_item.line_end = line_end;

  // decode when the output register is empty or being emptied
  assign step = full && (!out_valid || !out_stall);

  pbsd_in_reg u_in_reg (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .take(step),
    .full(full),
    .item(item)
  );

  pbsd_core #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(step),
    .item(item),
    .line_width(line_width),
    .has_result(has_result),
    .pixel_value(res_value),
    .run_length(res_len),
    .start_column(res_start),
    .fills_line(res_fills)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      pixel_value <= res_value;
      run_length <= res_len;
      start_column <= res_start;
      fills_line <= res_fills;
    end
  end

endmodule

>>> tb/sv/packbits_scanline_decoder_tb.sv
`timescale 1ns / 1ps

module packbits_scanline_decoder_tb;
  import pbsd_pkg::*;

  localparam logic [CFG_W-1:0] MAX_WIDTH = 13'd4096;
  localparam int TARGET_ITEMS = 400;
  localparam int HOLD_CYCLES = 40;

  typedef struct {
    logic [CODE_W-1:0] value;
    logic [LEN_W-1:0] len;
    logic [11:0] start;
    logic fills;
  } run_t;

  // mirrors the decoder line state and holds the runs still owed by the block
  class packbits_runs;
    logic [CFG_W-1:0] width_reg;
    logic [1:0] phase;
    logic [7:0] lit_left;
    logic [7:0] rep_cnt;
    logic [CFG_W-1:0] col;
    run_t runs_due[$];
    int errors;
    int runs_seen;
    int fills_seen;

    function new();
      width_reg = 13'd1;
      errors = 0;
      runs_seen = 0;
      fills_seen = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase = PH_HEADER;
      lit_left = 8'd0;
      rep_cnt = 8'd0;
      col = '0;
    endfunction

    function int pending();
      return runs_due.size();
    endfunction

    // returns 1 when the byte landed on a line that was not yet full
    function bit note_code_byte(logic [CODE_W-1:0] b, logic last);
      logic [CFG_W-1:0] w;
      logic [CFG_W-1:0] len;
      run_t r;
      bit emit;
      bit used;
      w = width_reg;
      if (w == 0) w = 13'd1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      emit = 1'b0;
      len = '0;
      used = (col < w);
      if (used) begin
        if (phase == PH_LITERAL) begin
          len = 13'd1;
          emit = 1'b1;
          if (lit_left > 0) lit_left = lit_left - 8'd1;
          if (lit_left == 0) phase = PH_HEADER;
        end else if (phase == PH_REPEAT) begin
          len = 13'(rep_cnt);
          if (len > w - col) len = w - col;
          emit = 1'b1;
          rep_cnt = 8'd0;
          phase = PH_HEADER;
        end else begin
          // the unused phase code decodes as a header too
          if (b < 8'h80) begin
            lit_left = b + 8'd1;
            phase = PH_LITERAL;
          end else if (b != HDR_NOP) begin
            rep_cnt = 8'(9'd257 - 9'(b));
            phase = PH_REPEAT;
          end else begin
            phase = PH_HEADER;
          end
        end
      end
      if (emit) begin
        r.value = b;
        r.len = len[LEN_W-1:0];
        r.start = col[11:0];
        col = col + len;
        r.fills = (col == w);
        runs_due.push_back(r);
      end
      if (last) clear_line();
      return used;
    endfunction

    function void check_run(logic [CODE_W-1:0] pv, logic [LEN_W-1:0] rl,
                            logic [11:0] sc, logic fl);
      run_t e;
      if (runs_due.size() == 0) begin
        $error("run with none expected: value %0h length %0d column %0d", pv, rl, sc);
        errors++;
        return;
      end
      e = runs_due.pop_front();
      runs_seen++;
      if (e.fills) fills_seen++;
      if (pv !== e.value) begin
        $error("pixel_value: expected %0h, got %0h", e.value, pv);
        errors++;
      end
      if (rl !== e.len) begin
        $error("run_length: expected %0d, got %0d", e.len, rl);
        errors++;
      end
      if (sc !== e.start) begin
        $error("start_column: expected %0d, got %0d", e.start, sc);
        errors++;
      end
      if (fl !== e.fills) begin
        $error("fills_line: expected %0b, got %0b", e.fills, fl);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CODE_W-1:0] code_byte = '0;
  logic line_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CODE_W-1:0] pixel_value;
  logic [LEN_W-1:0] run_length;
  logic [11:0] start_column;
  logic fills_line;

  packbits_runs tracker = new();
  logic [CODE_W-1:0] line_bytes[$];
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int used_items = 0;
  int total_items = 0;
  int n_widths = 0;

  packbits_scanline_decoder DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .code_byte(code_byte),
    .line_end(line_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_value(pixel_value),
    .run_length(run_length),
    .start_column(start_column),
    .fills_line(fills_line)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[packbits_scanline_decoder] ERROR");
    $finish;
  end

  task automatic send_code(input logic [CODE_W-1:0] b, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    code_byte <= b;
    line_end <= last;
    do @(posedge clk); while (in_stall);
    total_items++;
    if (tracker.note_code_byte(b, last)) used_items++;
  endtask

  // wait until every owed run is out, then let trailing no-result bytes clear
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.width_reg = v;
    n_widths++;
  endtask

  task automatic build_line(input int packets);
    int n;
    int cut;
    line_bytes.delete();
    repeat (packets) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
          line_bytes.push_back(8'(n));
          repeat (n + 1) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        5, 6, 7, 8: begin
          line_bytes.push_back(8'($urandom_range(129, 255)));
          line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: line_bytes.push_back(HDR_NOP);
      endcase
    end
    // sometimes end the line inside a run
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, 3);
      while (cut > 0 && line_bytes.size() > 1) begin
        void'(line_bytes.pop_back());
        cut--;
      end
    end
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_code(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_code(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
  endtask

  // exactly fills a 4096 line: 31 runs of 128, one of 127, one literal at 4095
  task automatic fill_wide_line();
    repeat (31) begin
      send_code(8'h81, 1'b0);
      send_code(8'($urandom_range(0, 255)), 1'b0);
    end
    send_code(8'h82, 1'b0);
    send_code(8'($urandom_range(0, 255)), 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'h05, 1'b1);
  endtask

  initial begin
    int phase_no;
    logic [CFG_W-1:0] w;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset width of one: repeat clipped to a single pixel, rest ignored
    send_code(8'hFF, 1'b0);
    send_code(8'h11, 1'b0);
    send_code(8'h22, 1'b1);

    write_width(13'd8);
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'hAA, 1'b0);
    send_code(HDR_NOP, 1'b0);
    send_code(8'h81, 1'b0);
    send_code(8'h55, 1'b0);
    send_code(8'h03, 1'b0);
    send_code(8'h7F, 1'b1);
    // literal cut short by line end
    send_code(HDR_NOP, 1'b0);
    send_code(8'h02, 1'b0);
    send_code(8'h12, 1'b0);
    send_code(8'h34, 1'b1);
    // repeat header as the last byte
    send_code(8'hFE, 1'b1);
    // long literal filling the line on its last byte
    send_code(8'h7F, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'h5A, 1'b0);
    send_code(8'hA5, 1'b0);
    send_code(8'h01, 1'b0);
    send_code(8'h80, 1'b0);
    send_code(8'h7F, 1'b0);
    send_code(8'hFE, 1'b1);

    // out of range widths clamp to 1 and to the maximum
    write_width(13'd0);
    build_line(3);
    send_line();
    write_width(13'h1FFF);
    build_line(6);
    send_line();
    fill_wide_line();
    write_width(13'd4097);
    build_line(4);
    send_line();
    write_width(MAX_WIDTH);
    fill_wide_line();

    // first two rounds run without idling, the first one under a long output hold
    phase_no = 0;
    while (phase_no < 2 || total_items < TARGET_ITEMS) begin
      if ($urandom_range(0, 3) == 0) w = 13'($urandom_range(0, 8191));
      else w = 13'($urandom_range(1, 160));
      write_width(w);
      quiet = (phase_no == 0) || (phase_no == 1);
      if (phase_no == 0) hold_req = 1'b1;
      repeat ((phase_no == 0) ? 6 : $urandom_range(2, 6)) begin
        if ($urandom_range(0, 4) == 0) begin
          send_noise($urandom_range(1, 8));
        end else begin
          build_line($urandom_range(1, 6));
          send_line();
        end
      end
      phase_no++;
    end
    quiet = 1'b0;

    settle();
    $display("checked %0d runs (%0d filling a line) from %0d code bytes, %0d on open lines",
             tracker.runs_seen, tracker.fills_seen, total_items, used_items);
    $display("covered %0d line width settings incl. clamped ones and a full 4096 line",
             n_widths);
    if (tracker.errors == 0) begin
      $display("[packbits_scanline_decoder] OK");
    end else begin
      $display("[packbits_scanline_decoder] ERROR");
    end
    $finish;
  end

  // result side: check accepted runs, then pick the next stall value
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        tracker.check_run(pixel_value, run_length, start_column, fills_line);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!quiet && $urandom_range(0, 99) < 12);
      end
    end
  end

endmodule
